### rtl/websocket_frame_receiver_defines.svh
// assertion macros for the websocket frame receiver checker
// expects clk and rst_n in the scope of use, no other dependencies
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("websocket_frame_receiver: check failed");

// next-cycle implication, disabled during reset
`define WSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("websocket_frame_receiver: check failed");

`endif

### rtl/wsr_pkg.sv
// shared types, codes and widths of the websocket frame receiver
// no dependencies
`timescale 1ns / 1ps

package wsr_pkg;

  localparam int BYTE_W     = 8;
  localparam int OPC_W      = 4;
  localparam int ERR_W      = 3;
  localparam int LEN_W      = 64;
  localparam int KEY_W      = 32;
  localparam int MAXLEN_W   = 32;
  localparam int POL_W      = 2;
  localparam int FBL_W      = 4;
  localparam int MPH_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } wsr_phase_t;

  localparam logic [ERR_W-1:0] ERR_RESERVED     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_CONTINUATION = 3'd1;
  localparam logic [ERR_W-1:0] ERR_FRAG_CONTROL = 3'd2;
  localparam logic [ERR_W-1:0] ERR_MASK_POLICY  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG     = 3'd4;
  localparam logic [ERR_W-1:0] ERR_OPCODE       = 3'd5;

  localparam logic [POL_W-1:0] POL_REQUIRE = 2'd1;
  localparam logic [POL_W-1:0] POL_FORBID  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 2'd1;

  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 32'd1048576;

  localparam logic [OPC_W-1:0] OP_CONT       = 4'd0;
  localparam logic [OPC_W-1:0] OP_FIRST_RSVD = 4'd3;
  localparam logic [OPC_W-1:0] OP_LAST_RSVD  = 4'd7;
  localparam logic [OPC_W-1:0] OP_CTRL_RSVD  = 4'd11;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [FBL_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [FBL_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [FBL_W-1:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] key;
    logic              byte_valid;
    logic [OPC_W-1:0]  opcode;
    logic              is_control;
    logic              message_end;
    logic              error_valid;
    logic [ERR_W-1:0]  error_code;
  } wsr_result_t;

endpackage

### rtl/websocket_frame_receiver.sv
// top level of the websocket frame receiver: parser, result queue and output stage
// depends on wsr_pkg, wsr_front, wsr_fifo, wsr_back
`timescale 1ns / 1ps
//
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] rx_byte
//  out_    | master    | tdata, tuser, tlast (one result beat)
//  cfg_    | slave     | cfg_index, cfg_data (register write)
//
//  one input byte per cycle; the parser updates its state in the cycle it takes a byte
//  a result beat reaches out_ through a queue write, then the output register
//  in_tready drops only while the two-entry queue is full; cfg_ready is always high
//  synchronous active-low reset, no clearing pass; after a protocol error bytes are
//  taken and dropped until reset

module websocket_frame_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wsr_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] rx_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] payload_byte, [8] byte_valid, [12:9] message_opcode, [15:13] error_code
  output logic [wsr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [wsr_pkg::OUT_USER_W-1:0]    out_tuser,  // [0] is_control, [1] error_valid
  output logic                              out_tlast,  // message_end
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsr_pkg::MAXLEN_W-1:0]      cfg_data
);
  import wsr_pkg::*;

  logic        res_valid;
  wsr_result_t res;
  logic        q_full, q_not_empty, q_pop;
  wsr_result_t q_head;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;

  wsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_tvalid && in_tready),
    .rx_byte   (in_tdata),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  wsr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

### rtl/wsr_front.sv
// frame parser: takes one byte per beat, tracks the frame header and checks the protocol
// depends on wsr_pkg; produces one wsr_result_t per result-bearing byte
`timescale 1ns / 1ps

module wsr_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               byte_fire,
  input  logic [wsr_pkg::BYTE_W-1:0]         rx_byte,
  input  logic                               cfg_fire,
  input  logic [wsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsr_pkg::MAXLEN_W-1:0]       cfg_data,
  output logic                               res_valid,
  output wsr_pkg::wsr_result_t               res
);
  import wsr_pkg::*;

  wsr_phase_t              phase_r, phase_nxt;
  logic [FBL_W-1:0]        fbl_r, fbl_nxt;
  logic [LEN_W-1:0]        frame_length_r, frame_length_nxt;
  logic [LEN_W-1:0]        message_total_r, message_total_nxt;
  logic [KEY_W-1:0]        mask_key_r, mask_key_nxt;
  logic [MPH_W-1:0]        mask_phase_r, mask_phase_nxt;
  logic                    frame_masked_r, frame_masked_nxt;
  logic                    frame_final_r, frame_final_nxt;
  logic                    expect_first_r, expect_first_nxt;
  logic [OPC_W-1:0]        data_opcode_r, data_opcode_nxt;
  logic [OPC_W-1:0]        control_opcode_r, control_opcode_nxt;
  logic                    in_control_r, in_control_nxt;
  logic                    dead_r, dead_nxt;
  logic [POL_W-1:0]        mask_policy_r;
  logic [MAXLEN_W-1:0]     max_len_r;

  logic                    fire;
  logic                    is_hdr, is_len, is_ext, is_mask, is_pay;
  logic [OPC_W-1:0]        hdr_op;
  logic                    hdr_fin, hdr_ctl, hdr_err;
  logic [ERR_W-1:0]        hdr_code;
  logic [6:0]              len7;
  logic                    len_short, pol_err;
  logic                    len_done, key_done, cur_masked, go_mask, enter;
  logic [LEN_W-1:0]        new_len, ent_len, ent_total, total_upd;
  logic [LEN_W:0]          total_sum;
  logic                    too_long, ent_empty, last_frame, pay_end;
  logic                    err;
  logic [ERR_W-1:0]        err_code;
  logic [OPC_W-1:0]        cur_opcode;
  logic [BYTE_W-1:0]       key_byte;

  assign fire    = byte_fire && !dead_r;
  assign is_len  = (phase_r == PH_LEN);
  assign is_ext  = (phase_r == PH_EXT);
  assign is_mask = (phase_r == PH_MASK);
  assign is_pay  = (phase_r == PH_PAYLOAD);
  assign is_hdr  = !(is_len || is_ext || is_mask || is_pay);

  // header byte checks in priority order
  assign hdr_op  = rx_byte[OPC_W-1:0];
  assign hdr_fin = rx_byte[7];
  assign hdr_ctl = hdr_op[3];
  always_comb begin
    hdr_err  = 1'b1;
    hdr_code = ERR_RESERVED;
    if (rx_byte[6:4] != 3'd0) begin
      hdr_code = ERR_RESERVED;
    end else if (expect_first_r && hdr_op == OP_CONT) begin
      hdr_code = ERR_CONTINUATION;
    end else if (!expect_first_r && !hdr_ctl && hdr_op != OP_CONT) begin
      hdr_code = ERR_CONTINUATION;
    end else if ((hdr_op >= OP_FIRST_RSVD && hdr_op <= OP_LAST_RSVD) ||
                 hdr_op >= OP_CTRL_RSVD) begin
      hdr_code = ERR_OPCODE;
    end else if (hdr_ctl && !hdr_fin) begin
      hdr_code = ERR_FRAG_CONTROL;
    end else begin
      hdr_err = 1'b0;
    end
  end

  // length byte
  assign len7      = rx_byte[6:0];
  assign len_short = (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64);
  assign pol_err   = (mask_policy_r == POL_REQUIRE && !rx_byte[7]) ||
                     (mask_policy_r == POL_FORBID && rx_byte[7]);

  assign new_len    = is_len ? {{(LEN_W-7){1'b0}}, len7}
                             : {frame_length_r[LEN_W-BYTE_W-1:0], rx_byte};
  assign len_done   = (is_len && !pol_err && len_short) ||
                      (is_ext && fbl_r == FBL_W'(1));
  assign key_done   = is_mask && fbl_r == FBL_W'(1);
  assign cur_masked = is_len ? rx_byte[7] : frame_masked_r;
  assign go_mask    = len_done && cur_masked;
  assign enter      = (len_done && !cur_masked) || key_done;

  // running message total, saturating
  assign total_sum = {1'b0, message_total_r} + {1'b0, new_len};
  always_comb begin
    if (in_control_r) begin
      total_upd = message_total_r;
    end else if (expect_first_r) begin
      total_upd = new_len;
    end else if (total_sum[LEN_W]) begin
      total_upd = '1;
    end else begin
      total_upd = total_sum[LEN_W-1:0];
    end
  end

  assign ent_len    = is_mask ? frame_length_r : new_len;
  assign ent_total  = in_control_r ? ent_len : (is_mask ? message_total_r : total_upd);
  assign too_long   = (|ent_total[LEN_W-1:MAXLEN_W]) || (ent_total[MAXLEN_W-1:0] >= max_len_r);
  assign ent_empty  = (ent_len == '0);
  assign last_frame = in_control_r || frame_final_r;
  assign pay_end    = (frame_length_r == LEN_W'(1));
  assign cur_opcode = in_control_r ? control_opcode_r : data_opcode_r;

  always_comb begin
    case (mask_phase_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    err      = 1'b0;
    err_code = ERR_RESERVED;
    if (is_hdr && hdr_err) begin
      err      = 1'b1;
      err_code = hdr_code;
    end else if (is_len && pol_err) begin
      err      = 1'b1;
      err_code = ERR_MASK_POLICY;
    end else if (enter && too_long) begin
      err      = 1'b1;
      err_code = ERR_TOO_LONG;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire && !err) begin
      if (go_mask) begin
        phase_nxt = PH_MASK;
      end else if (enter) begin
        phase_nxt = ent_empty ? PH_HEADER : PH_PAYLOAD;
      end else begin
        case (phase_r)
          PH_LEN:     phase_nxt = PH_EXT;
          PH_EXT:     phase_nxt = PH_EXT;
          PH_MASK:    phase_nxt = PH_MASK;
          PH_PAYLOAD: phase_nxt = pay_end ? PH_HEADER : PH_PAYLOAD;
          default:    phase_nxt = PH_LEN;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    fbl_nxt            = fbl_r;
    frame_length_nxt   = frame_length_r;
    message_total_nxt  = message_total_r;
    mask_key_nxt       = mask_key_r;
    mask_phase_nxt     = mask_phase_r;
    frame_masked_nxt   = frame_masked_r;
    frame_final_nxt    = frame_final_r;
    expect_first_nxt   = expect_first_r;
    data_opcode_nxt    = data_opcode_r;
    control_opcode_nxt = control_opcode_r;
    in_control_nxt     = in_control_r;
    dead_nxt           = dead_r;
    res_valid          = 1'b0;
    res                = '0;
    if (fire) begin
      if (err) begin
        dead_nxt        = 1'b1;
        res_valid       = 1'b1;
        res.error_valid = 1'b1;
        res.error_code  = err_code;
      end else begin
        case (phase_r)
          PH_LEN: begin
            frame_masked_nxt = rx_byte[7];
            frame_length_nxt = len_short ? new_len : '0;
            fbl_nxt          = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          end
          PH_EXT: begin
            frame_length_nxt = new_len;
            fbl_nxt          = fbl_r - FBL_W'(1);
          end
          PH_MASK: begin
            mask_key_nxt = {mask_key_r[KEY_W-BYTE_W-1:0], rx_byte};
            fbl_nxt      = fbl_r - FBL_W'(1);
          end
          PH_PAYLOAD: begin
            mask_phase_nxt   = mask_phase_r + MPH_W'(1);
            frame_length_nxt = frame_length_r - LEN_W'(1);
            if (pay_end && !in_control_r) begin
              expect_first_nxt = frame_final_r;
            end
            res_valid       = 1'b1;
            res.data        = rx_byte;
            res.key         = frame_masked_r ? key_byte : '0;
            res.byte_valid  = 1'b1;
            res.opcode      = cur_opcode;
            res.is_control  = in_control_r;
            res.message_end = pay_end && last_frame;
          end
          default: begin
            in_control_nxt  = hdr_ctl;
            frame_final_nxt = hdr_fin;
            if (hdr_ctl) begin
              control_opcode_nxt = hdr_op;
            end else if (hdr_op != OP_CONT) begin
              data_opcode_nxt = hdr_op;
            end
          end
        endcase
        if (len_done) begin
          message_total_nxt = total_upd;
        end
        if (go_mask) begin
          mask_key_nxt = '0;
          fbl_nxt      = KEY_BYTES;
        end
        if (enter) begin
          mask_phase_nxt = '0;
          if (ent_empty) begin
            if (!in_control_r) begin
              expect_first_nxt = frame_final_r;
            end
            if (last_frame) begin
              res_valid       = 1'b1;
              res.opcode      = cur_opcode;
              res.is_control  = in_control_r;
              res.message_end = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HEADER;
      fbl_r            <= '0;
      frame_length_r   <= '0;
      message_total_r  <= '0;
      mask_key_r       <= '0;
      mask_phase_r     <= '0;
      frame_masked_r   <= 1'b0;
      frame_final_r    <= 1'b0;
      expect_first_r   <= 1'b1;
      data_opcode_r    <= '0;
      control_opcode_r <= '0;
      in_control_r     <= 1'b0;
      dead_r           <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      fbl_r            <= fbl_nxt;
      frame_length_r   <= frame_length_nxt;
      message_total_r  <= message_total_nxt;
      mask_key_r       <= mask_key_nxt;
      mask_phase_r     <= mask_phase_nxt;
      frame_masked_r   <= frame_masked_nxt;
      frame_final_r    <= frame_final_nxt;
      expect_first_r   <= expect_first_nxt;
      data_opcode_r    <= data_opcode_nxt;
      control_opcode_r <= control_opcode_nxt;
      in_control_r     <= in_control_nxt;
      dead_r           <= dead_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_policy_r <= '0;
      max_len_r     <= MAXLEN_RESET;
    end else if (cfg_fire) begin
      if (cfg_index == REG_MASK_POLICY) begin
        mask_policy_r <= cfg_data[POL_W-1:0];
      end else if (cfg_index == REG_MAX_LEN) begin
        max_len_r <= cfg_data;
      end
    end
  end

endmodule

### rtl/wsr_fifo.sv
// short result queue between parser and output stage
// depends on wsr_pkg for depth and entry type
`timescale 1ns / 1ps

module wsr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wsr_pkg::wsr_result_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output wsr_pkg::wsr_result_t head
);
  import wsr_pkg::*;

  wsr_result_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/wsr_back.sv
// output stage: unmasks queued bytes and holds the result beat until taken
// depends on wsr_pkg
`timescale 1ns / 1ps

module wsr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  wsr_pkg::wsr_result_t              q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wsr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [wsr_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);
  import wsr_pkg::*;

  logic              valid_r;
  logic [BYTE_W-1:0] payload_r;
  logic              byte_valid_r;
  logic [OPC_W-1:0]  opcode_r;
  logic              is_control_r;
  logic              message_end_r;
  logic              error_valid_r;
  logic [ERR_W-1:0]  error_code_r;

  assign q_pop = q_not_empty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      payload_r     <= q_head.data ^ q_head.key;
      byte_valid_r  <= q_head.byte_valid;
      opcode_r      <= q_head.opcode;
      is_control_r  <= q_head.is_control;
      message_end_r <= q_head.message_end;
      error_valid_r <= q_head.error_valid;
      error_code_r  <= q_head.error_code;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {error_code_r, opcode_r, byte_valid_r, payload_r};
  assign out_tuser  = {error_valid_r, is_control_r};
  assign out_tlast  = message_end_r;

endmodule

### rtl/wsr_checker.sv
// port-level checks on the result channel of the websocket frame receiver
// depends on websocket_frame_receiver_defines.svh; bound to the top level below
`timescale 1ns / 1ps

module wsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  `include "websocket_frame_receiver_defines.svh"

  `WSR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `WSR_ASSERT_NOW(a_err_clean, out_tvalid && out_tuser[1], !out_tdata[8] && !out_tlast && !out_tuser[0])
  `WSR_ASSERT_NOW(a_err_code, out_tvalid && out_tuser[1], out_tdata[15:13] != 3'd6 && out_tdata[15:13] != 3'd7)
  `WSR_ASSERT_NOW(a_empty_zero, out_tvalid && !out_tdata[8], out_tdata[7:0] == 8'd0)
  `WSR_ASSERT_NEXT(a_err_last, out_tvalid && out_tready && out_tuser[1], !out_tvalid)

endmodule

bind websocket_frame_receiver wsr_checker u_wsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### tb/websocket_frame_receiver_tb.sv
// self-checking testbench for websocket_frame_receiver: directed table, then random frames
// predicts beats by its own parser or the table's beat rows; depends on wsr_pkg and the rtl only
`timescale 1ns / 1ps

module websocket_frame_receiver_tb;
  import wsr_pkg::*;

  localparam logic [OPC_W-1:0] OP_TEXT   = 4'd1;
  localparam logic [OPC_W-1:0] OP_BINARY = 4'd2;
  localparam logic [OPC_W-1:0] OP_CLOSE  = 4'd8;
  localparam logic [OPC_W-1:0] OP_PING   = 4'd9;
  localparam logic [OPC_W-1:0] OP_PONG   = 4'd10;
  localparam logic [POL_W-1:0] POL_NONE   = 2'd0;
  localparam logic [POL_W-1:0] POL_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [BYTE_W-1:0] payload;
    logic              byte_valid;
    logic [OPC_W-1:0]  opcode;
    logic              is_control;
    logic              message_end;
    logic              error_valid;
    logic [ERR_W-1:0]  error_code;
  } frame_result_t;

  typedef enum logic [1:0] {ROW_NONE, ROW_BEAT, ROW_PREDICT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [BYTE_W-1:0] rx;
    logic [BYTE_W-1:0] payload;
    logic              byte_valid;
    logic [OPC_W-1:0]  opcode;
    logic              is_control;
    logic              message_end;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [MAXLEN_W-1:0]   cfg_data;

  websocket_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow registers and parser state
  logic [POL_W-1:0]    policy_reg  = POL_NONE;
  logic [MAXLEN_W-1:0] max_len_reg = MAXLEN_RESET;
  wsr_phase_t          rx_phase      = PH_HEADER;
  logic [FBL_W-1:0]    rx_field_left = '0;
  logic [LEN_W-1:0]    rx_frame_len  = '0;
  logic [LEN_W-1:0]    rx_msg_total  = '0;
  logic [KEY_W-1:0]    rx_key        = '0;
  logic [MPH_W-1:0]    rx_key_pos    = '0;
  logic                rx_masked     = 1'b0;
  logic                rx_final      = 1'b0;
  logic                rx_want_first = 1'b1;
  logic [OPC_W-1:0]    rx_data_op    = '0;
  logic [OPC_W-1:0]    rx_ctl_op     = '0;
  logic                rx_in_ctl     = 1'b0;
  logic                rx_dead       = 1'b0;

  frame_result_t parsed_beats[$];
  int            mismatches = 0;
  int            bytes_sent = 0;
  bit            gaps_on    = 1'b1;
  bit            stalls_on  = 1'b1;
  bit            hold_now   = 1'b0;

  script_row_t directed_rows [0:25] = '{
    '{ROW_NONE,    8'h81, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_BEAT,    8'h00, 8'h00, 1'b0, OP_TEXT,   1'b0, 1'b1},  // empty final text
    '{ROW_NONE,    8'h82, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'h01, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_BEAT,    8'hff, 8'hff, 1'b1, OP_BINARY, 1'b0, 1'b1},
    '{ROW_NONE,    8'h01, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},  // text, more fragments
    '{ROW_NONE,    8'h81, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'ha5, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'h5a, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'h0f, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'hf0, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_PREDICT, 8'h12, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'h89, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},  // ping between fragments
    '{ROW_BEAT,    8'h00, 8'h00, 1'b0, OP_PING,   1'b1, 1'b1},
    '{ROW_NONE,    8'h80, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},  // final continuation
    '{ROW_NONE,    8'h7e, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'h00, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'h02, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_PREDICT, 8'h00, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_PREDICT, 8'hff, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'h8a, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},  // masked empty pong
    '{ROW_NONE,    8'h80, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'hff, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'hff, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_NONE,    8'hff, 8'h00, 1'b0, 4'd0,      1'b0, 1'b0},
    '{ROW_BEAT,    8'hff, 8'h00, 1'b0, OP_PONG,   1'b1, 1'b1}
  };

  function automatic logic [OPC_W-1:0] current_opcode();
    return rx_in_ctl ? rx_ctl_op : rx_data_op;
  endfunction

  function automatic frame_result_t error_beat(input logic [ERR_W-1:0] code);
    frame_result_t r = '0;
    rx_dead = 1'b1;
    r.error_valid = 1'b1;
    r.error_code = code;
    return r;
  endfunction

  function automatic bit close_frame();
    bit last = rx_in_ctl || rx_final;
    if (!rx_in_ctl) rx_want_first = rx_final;
    rx_phase = PH_HEADER;
    return last;
  endfunction

  function automatic bit enter_payload(output frame_result_t r);
    logic [LEN_W-1:0] total;
    r = '0;
    total = rx_in_ctl ? rx_frame_len : rx_msg_total;
    if (total >= LEN_W'(max_len_reg)) begin
      r = error_beat(ERR_TOO_LONG);
      return 1'b1;
    end
    rx_key_pos = '0;
    if (rx_frame_len == 0) begin
      if (close_frame()) begin
        r.opcode = current_opcode();
        r.is_control = rx_in_ctl;
        r.message_end = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    rx_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit length_done(output frame_result_t r);
    r = '0;
    if (!rx_in_ctl) begin
      if (rx_want_first) rx_msg_total = rx_frame_len;
      else if (rx_msg_total > ~rx_frame_len) rx_msg_total = '1;
      else rx_msg_total = rx_msg_total + rx_frame_len;
    end
    if (rx_masked) begin
      rx_key = '0;
      rx_field_left = KEY_BYTES;
      rx_phase = PH_MASK;
      return 1'b0;
    end
    return enter_payload(r);
  endfunction

  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output frame_result_t r);
    logic [OPC_W-1:0]  op;
    logic [BYTE_W-1:0] key_byte;
    logic              ctl;
    r = '0;
    if (rx_dead) return 1'b0;
    case (rx_phase)
      PH_LEN: begin
        rx_masked = b[7];
        if ((policy_reg == POL_REQUIRE && !rx_masked) ||
            (policy_reg == POL_FORBID && rx_masked)) begin
          r = error_beat(ERR_MASK_POLICY);
          return 1'b1;
        end
        rx_frame_len = '0;
        if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
          rx_field_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          rx_phase = PH_EXT;
          return 1'b0;
        end
        rx_frame_len = LEN_W'(b[6:0]);
        return length_done(r);
      end
      PH_EXT: begin
        rx_frame_len = {rx_frame_len[LEN_W-9:0], b};
        rx_field_left = rx_field_left - FBL_W'(1);
        if (rx_field_left == 0) return length_done(r);
        return 1'b0;
      end
      PH_MASK: begin
        rx_key = {rx_key[KEY_W-9:0], b};
        rx_field_left = rx_field_left - FBL_W'(1);
        if (rx_field_left == 0) return enter_payload(r);
        return 1'b0;
      end
      PH_PAYLOAD: begin
        key_byte = rx_masked ? 8'(rx_key >> (24 - 8 * int'(rx_key_pos))) : 8'h00;
        rx_key_pos = rx_key_pos + MPH_W'(1);
        rx_frame_len = rx_frame_len - LEN_W'(1);
        if (rx_frame_len == 0) r.message_end = close_frame();
        r.payload = b ^ key_byte;
        r.byte_valid = 1'b1;
        r.opcode = current_opcode();
        r.is_control = rx_in_ctl;
        return 1'b1;
      end
      default: begin
        op = b[3:0];
        ctl = op[3];
        if (b[6:4] != 3'b000) begin
          r = error_beat(ERR_RESERVED);
          return 1'b1;
        end
        if ((rx_want_first && op == OP_CONT) ||
            (!rx_want_first && !ctl && op != OP_CONT)) begin
          r = error_beat(ERR_CONTINUATION);
          return 1'b1;
        end
        if ((op >= OP_FIRST_RSVD && op <= OP_LAST_RSVD) || op >= OP_CTRL_RSVD) begin
          r = error_beat(ERR_OPCODE);
          return 1'b1;
        end
        if (ctl && !b[7]) begin
          r = error_beat(ERR_FRAG_CONTROL);
          return 1'b1;
        end
        rx_in_ctl = ctl;
        rx_final = b[7];
        if (ctl) rx_ctl_op = op;
        else if (op != OP_CONT) rx_data_op = op;
        rx_phase = PH_LEN;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input row_kind_t how,
                           input frame_result_t typed);
    frame_result_t r;
    bit            has;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    has = parse_byte(b, r);
    if (how == ROW_PREDICT && has) parsed_beats.push_back(r);
    else if (how == ROW_BEAT) parsed_beats.push_back(typed);
    bytes_sent++;
  endtask

  task automatic feed(input logic [BYTE_W-1:0] b);
    send_byte(b, ROW_PREDICT, '0);
  endtask

  // wait until every predicted beat has come out and the pipe is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (parsed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAXLEN_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MASK_POLICY) policy_reg = val[POL_W-1:0];
    else if (idx == REG_MAX_LEN) max_len_reg = val;
  endtask

  function automatic int pick_len(input int limit);
    int pick = $urandom_range(0, 15);
    int hi;
    hi = (pick < 10) ? 12 : (pick < 13) ? 125 : 300;
    if (hi > limit) hi = limit;
    return (hi <= 0) ? 0 : $urandom_range(0, hi);
  endfunction

  function automatic logic [OPC_W-1:0] pick_control();
    case ($urandom_range(0, 2))
      0: return OP_CLOSE;
      1: return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  task automatic send_frame(input logic fin, input logic [OPC_W-1:0] op,
                            input logic [LEN_W-1:0] len, input logic bad_mask);
    logic             masked;
    logic [KEY_W-1:0] key;
    int               form;
    masked = (policy_reg == POL_REQUIRE) ? 1'b1 :
             (policy_reg == POL_FORBID) ? 1'b0 : 1'($urandom_range(0, 1));
    masked = masked ^ bad_mask;
    key = $urandom;
    if (len < 126) form = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2);
    else if (len < 65536 && $urandom_range(0, 4) != 0) form = 1;
    else form = 2;
    feed({fin, 3'b000, op});
    case (form)
      0: feed({masked, len[6:0]});
      1: begin
        feed({masked, LEN7_EXT16});
        feed(len[15:8]);
        feed(len[7:0]);
      end
      default: begin
        feed({masked, LEN7_EXT64});
        for (int j = 7; j >= 0 && !rx_dead; j--) feed(len[8*j +: 8]);
      end
    endcase
    for (int j = 3; j >= 0 && masked && !rx_dead; j--) feed(key[8*j +: 8]);
    for (logic [LEN_W-1:0] i = 0; i < len && !rx_dead; i++) begin
      feed(8'($urandom_range(0, 255)));
    end
  endtask

  // one whole message: a lone control frame, or data fragments with control frames at random between
  task automatic send_message();
    int               cap;
    int               nfrag;
    int               len;
    int               spent;
    logic [OPC_W-1:0] op;
    cap = (max_len_reg > 2000) ? 2000 : int'(max_len_reg) - 1;
    if ($urandom_range(0, 3) == 0) begin
      send_frame(1'b1, pick_control(), LEN_W'(pick_len(cap > 125 ? 125 : cap)), 1'b0);
      return;
    end
    op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
    nfrag = $urandom_range(1, 4);
    spent = 0;
    for (int i = 0; i < nfrag; i++) begin
      len = pick_len(cap - spent);
      spent += len;
      send_frame(i == nfrag - 1, (i == 0) ? op : OP_CONT, LEN_W'(len), 1'b0);
      if (i != nfrag - 1 && $urandom_range(0, 2) == 0) begin
        send_frame(1'b1, pick_control(), LEN_W'(pick_len(cap > 125 ? 125 : cap)), 1'b0);
      end
    end
  endtask

  // ends the stream with one protocol error of a random kind, then bytes that are dropped
  task automatic break_stream();
    logic [OPC_W-1:0] op;
    case ($urandom_range(0, 5))
      0: feed({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), 4'($urandom_range(0, 15))});
      1: begin
        if ($urandom_range(0, 1)) begin
          feed({1'b1, 3'b000, OP_CONT});
        end else begin
          send_frame(1'b0, OP_TEXT, LEN_W'(pick_len(10)), 1'b0);
          feed({1'b1, 3'b000, OP_BINARY});
        end
      end
      2: feed({1'b0, 3'b000, pick_control()});
      3: begin
        write_reg(REG_MASK_POLICY,
                  MAXLEN_W'($urandom_range(0, 1) ? POL_REQUIRE : POL_FORBID));
        send_frame(1'b1, OP_BINARY, 4, 1'b1);
      end
      4: begin
        if ($urandom_range(0, 1)) begin
          write_reg(REG_MAX_LEN, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40));
          op = $urandom_range(0, 1) ? OP_TEXT : pick_control();
          send_frame(1'b1, op, LEN_W'(max_len_reg + $urandom_range(0, 5)), 1'b0);
        end else begin
          send_frame(1'b1, OP_BINARY, {32'($urandom_range(1, 32'hffff_ffff)), 32'($urandom)},
                     1'b0);
        end
      end
      default: begin
        op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        feed({1'($urandom_range(0, 1)), 3'b000, op});
      end
    endcase
    repeat (20) feed(8'($urandom_range(0, 255)));
  endtask

  // result side: random back-pressure, one long hold on request
  initial begin
    int stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_now) begin
        hold_now = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  frame_result_t want_beat;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (parsed_beats.size() == 0) begin
        mismatches++;
        $display("%0t unexpected beat: expected none, got data %0h user %0h last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want_beat = parsed_beats.pop_front();
        check_field("payload_byte", want_beat.payload, out_tdata[7:0]);
        check_field("byte_valid", 8'(want_beat.byte_valid), 8'(out_tdata[8]));
        check_field("message_opcode", 8'(want_beat.opcode), 8'(out_tdata[12:9]));
        check_field("error_code", 8'(want_beat.error_code), 8'(out_tdata[15:13]));
        check_field("is_control", 8'(want_beat.is_control), 8'(out_tuser[0]));
        check_field("error_valid", 8'(want_beat.error_valid), 8'(out_tuser[1]));
        check_field("message_end", 8'(want_beat.message_end), 8'(out_tlast));
      end
    end
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("websocket_frame_receiver_tb: done, errors");
    $finish;
  end

  initial begin
    frame_result_t want;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset configuration
    for (int i = 0; i < $size(directed_rows); i++) begin
      want = '0;
      want.payload     = directed_rows[i].payload;
      want.byte_valid  = directed_rows[i].byte_valid;
      want.opcode      = directed_rows[i].opcode;
      want.is_control  = directed_rows[i].is_control;
      want.message_end = directed_rows[i].message_end;
      send_byte(directed_rows[i].rx, directed_rows[i].kind, want);
    end

    write_reg(REG_MASK_POLICY, MAXLEN_W'(POL_REQUIRE));
    write_reg(REG_MAX_LEN, 32'hffff_ffff);
    while (bytes_sent < 450) send_message();

    // small length limit, and one long output hold while bytes keep coming
    write_reg(REG_MASK_POLICY, MAXLEN_W'(POL_FORBID));
    write_reg(REG_MAX_LEN, 64);
    hold_now = 1'b1;
    send_frame(1'b1, OP_BINARY, 40, 1'b0);
    while (bytes_sent < 900) send_message();

    write_reg(REG_MASK_POLICY, MAXLEN_W'(POL_UNUSED));
    write_reg(REG_MAX_LEN, MAXLEN_RESET);
    while (bytes_sent < 1300) send_message();

    write_reg(REG_MASK_POLICY, MAXLEN_W'(POL_NONE));
    write_reg(REG_MAX_LEN, 4096);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    while (bytes_sent < 1600) send_message();

    break_stream();
    settle();
    if (mismatches == 0) $display("websocket_frame_receiver_tb: done, clean");
    else $display("websocket_frame_receiver_tb: done, errors");
    $finish;
  end

endmodule
